@@ src/stq_pkg.sv @@
// Package for the sorted timer queue: entry and cell status types,
// operation and status codes, and the per-tick result limit.
// No dependencies; every other file in src imports it.
package stq_pkg;

  localparam int TAG_W = 16;
  localparam int EXP_W = 32;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 3;

  // Most expired entries reported by one tick.
  localparam int MAX_RESULTS = 16;
  localparam int TICK_CNT_W = $clog2(MAX_RESULTS);

  // Operation codes on in_mode.
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

  // Status codes on out_status.
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd5;

  // One timer held in a cell.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [EXP_W-1:0] expiry;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_POP    = 2'd3
  } cell_cmd_t;

  // Flags that a cell hands to its right neighbor and to the controller.
  typedef struct packed {
    logic le;    // valid and expiry <= key expiry
    logic gone;  // the key tag was found in this cell or one to its left
    logic hit;   // this cell holds the key tag
    logic due;   // valid and expiry <= current time
  } cell_stat_t;

endpackage

@@ src/sorted_timer_queue.sv @@
// Sorted timer queue top level: a row of CAPACITY cells kept in ascending
// expiry order, and the controller that runs add, adjust, delete and tick.
// Depends on stq_pkg and stq_cell.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | start, busy            | in_mode, in_conn_tag, in_expire_time, in_now_time
//  result   | out_strobe (one cycle) | out_status, out_expired_tag, out_last
//
// Add, delete and an adjust of an absent tag pass through the execute state;
// an adjust of a held tag closes the gap in the execute state and opens the
// new slot in the reinsert state, and a tick reports one expired entry per
// cell-row shift, or a none-due result if no entry has expired.
// Each result is shown for one cycle right after the edge that decides it.
// Reset empties the row at once by clearing the valid bits; no sweep is run.
// The receiver cannot stall, so results never wait.
module sorted_timer_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [stq_pkg::MODE_W-1:0]   in_mode,
  input  logic [stq_pkg::TAG_W-1:0]    in_conn_tag,
  input  logic [stq_pkg::EXP_W-1:0]    in_expire_time,
  input  logic [stq_pkg::EXP_W-1:0]    in_now_time,
  output logic                         out_strobe,
  output logic [stq_pkg::STATUS_W-1:0] out_status,
  output logic [stq_pkg::TAG_W-1:0]    out_expired_tag,
  output logic                         out_last
);
  import stq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_REINS = 4'b0100,
    S_TICK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [TAG_W-1:0]  tag_r;
  logic [EXP_W-1:0]  exp_r;
  logic [EXP_W-1:0]  now_r;

  logic [TICK_CNT_W-1:0] tick_cnt_r, tick_cnt_nxt;

  logic                strobe_r, strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [TAG_W-1:0]    xtag_r, xtag_nxt;
  logic                last_r, last_nxt;

  cell_cmd_t  cmd;
  entry_t     ent [CAPACITY];
  cell_stat_t stat [CAPACITY];

  logic accept;
  logic any_hit;
  logic full;
  logic tick_last;

  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign any_hit = stat[CAPACITY-1].gone;
  assign full    = ent[CAPACITY-1].valid;

  // The row of cells, linked to both neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t     left_ent;
    cell_stat_t left_stat;
    entry_t     right_ent;

    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign left_stat = '{le: 1'b1, gone: 1'b0, hit: 1'b0, due: 1'b0};
    end else begin : g_mid_l
      assign left_ent  = ent[i-1];
      assign left_stat = stat[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .key_tag   (tag_r),
      .key_exp   (exp_r),
      .now_time  (now_r),
      .left_ent  (left_ent),
      .left_stat (left_stat),
      .right_ent (right_ent),
      .ent_o     (ent[i]),
      .stat_o    (stat[i])
    );
  end

  // The tick's current result is its last when the next entry is not due
  // or the per-tick limit is reached.
  assign tick_last = !stat[1].due || (tick_cnt_r == TICK_CNT_W'(MAX_RESULTS - 1));

  // Controller: picks the row command and the result of each cycle.
  always_comb begin
    state_nxt    = state_r;
    cmd          = CMD_HOLD;
    tick_cnt_nxt = tick_cnt_r;
    strobe_nxt   = 1'b0;
    status_nxt   = ST_DONE;
    xtag_nxt     = '0;
    last_nxt     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tick_cnt_nxt = '0;
          state_nxt    = (in_mode == MODE_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_EXEC: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        case (mode_r)
          MODE_ADD: begin
            if (any_hit) begin
              status_nxt = ST_DUPLICATE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd = CMD_INSERT;
            end
          end
          MODE_ADJUST: begin
            if (!any_hit) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              // Close the gap now, reinsert in the next cycle.
              cmd        = CMD_REMOVE;
              strobe_nxt = 1'b0;
              state_nxt  = S_REINS;
            end
          end
          MODE_DELETE: begin
            if (!any_hit) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              cmd = CMD_REMOVE;
            end
          end
          default: begin
            status_nxt = ST_NOT_FOUND;
          end
        endcase
      end
      S_REINS: begin
        cmd        = CMD_INSERT;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_TICK: begin
        strobe_nxt = 1'b1;
        if (stat[0].due) begin
          // Report the head entry and shift the row left.
          cmd          = CMD_POP;
          status_nxt   = ST_EXPIRED;
          xtag_nxt     = ent[0].tag;
          last_nxt     = tick_last;
          tick_cnt_nxt = tick_cnt_r + 1'b1;
          if (tick_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          status_nxt = ST_NONE_DUE;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Captured item, tick counter and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      tag_r  <= in_conn_tag;
      exp_r  <= in_expire_time;
      now_r  <= in_now_time;
    end
    tick_cnt_r <= tick_cnt_nxt;
    status_r   <= status_nxt;
    xtag_r     <= xtag_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_expired_tag = xtag_r;
  assign out_last        = last_r;

endmodule

@@ src/stq_cell.sv @@
// One cell of the sorted timer row: holds a single entry and moves it
// left or right, or loads the new entry, as the broadcast command says.
// Depends on stq_pkg.
module stq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  stq_pkg::cell_cmd_t        cmd,
  input  logic [stq_pkg::TAG_W-1:0] key_tag,
  input  logic [stq_pkg::EXP_W-1:0] key_exp,
  input  logic [stq_pkg::EXP_W-1:0] now_time,
  input  stq_pkg::entry_t           left_ent,
  input  stq_pkg::cell_stat_t       left_stat,
  input  stq_pkg::entry_t           right_ent,
  output stq_pkg::entry_t           ent_o,
  output stq_pkg::cell_stat_t       stat_o
);
  import stq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // Compare the held entry against the key and the current time.
  always_comb begin
    stat_o.le   = ent_r.valid && (ent_r.expiry <= key_exp);
    stat_o.hit  = ent_r.valid && (ent_r.tag == key_tag);
    stat_o.gone = left_stat.gone || stat_o.hit;
    stat_o.due  = ent_r.valid && (ent_r.expiry <= now_time);
  end

  // Insert keeps cells at or below the key, loads the key at the first
  // larger one and shifts the rest right; remove shifts left from the hit, pop from the head.
  always_comb begin
    ent_nxt = ent_r;
    case (cmd)
      CMD_INSERT: begin
        if (!stat_o.le) begin
          if (left_stat.le) begin
            ent_nxt.valid  = 1'b1;
            ent_nxt.tag    = key_tag;
            ent_nxt.expiry = key_exp;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      CMD_REMOVE: begin
        if (stat_o.gone) begin
          ent_nxt = right_ent;
        end
      end
      CMD_POP: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Reset clears the valid bit; tag and expiry are loaded every cycle.
  always_ff @(posedge clk) begin
    ent_r.tag    <= ent_nxt.tag;
    ent_r.expiry <= ent_nxt.expiry;
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
  end

  assign ent_o = ent_r;

endmodule

@@ test/sorted_timer_queue_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timer_queue: directed and random add, adjust,
// delete and tick items, checked against an in-bench model of the sorted row.
// Depends on stq_pkg and the sorted_timer_queue RTL.
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int ROW_CAP = 16;

  // One expected result as it appears on the result ports.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } timer_result_t;

  // Shadow copy of the timer row and the results it predicts.
  class timer_scoreboard;
    logic [EXP_W-1:0] row_expiry[ROW_CAP];
    logic [TAG_W-1:0] row_tag[ROW_CAP];
    int               row_count;
    timer_result_t    due_results[$];
    int               errors;

    function new();
      row_count = 0;
      errors = 0;
    endfunction

    function int locate_tag(logic [TAG_W-1:0] tag);
      for (int i = 0; i < row_count; i++)
        if (row_tag[i] == tag) return i;
      return -1;
    endfunction

    function void close_gap(int pos);
      for (int i = pos; i + 1 < row_count; i++) begin
        row_expiry[i] = row_expiry[i + 1];
        row_tag[i] = row_tag[i + 1];
      end
      row_count--;
    endfunction

    // The new entry goes after every entry with an equal or earlier expiry.
    function void place_sorted(logic [TAG_W-1:0] tag, logic [EXP_W-1:0] expiry);
      int pos;
      pos = 0;
      while (pos < row_count && row_expiry[pos] <= expiry) pos++;
      for (int i = row_count; i > pos; i--) begin
        row_expiry[i] = row_expiry[i - 1];
        row_tag[i] = row_tag[i - 1];
      end
      row_expiry[pos] = expiry;
      row_tag[pos] = tag;
      row_count++;
    endfunction

    function void push_result(logic [STATUS_W-1:0] status, logic [TAG_W-1:0] tag,
                              logic last);
      timer_result_t r;
      r.status = status;
      r.tag = tag;
      r.last = last;
      due_results.push_back(r);
    endfunction

    // Work out the results of one accepted item and update the shadow row.
    function void note_item(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                            logic [EXP_W-1:0] expiry, logic [EXP_W-1:0] now);
      int pos;
      int n;
      pos = locate_tag(tag);
      case (mode)
        MODE_ADD: begin
          if (pos >= 0) begin
            push_result(ST_DUPLICATE, '0, 1'b1);
          end else if (row_count >= ROW_CAP) begin
            push_result(ST_FULL, '0, 1'b1);
          end else begin
            place_sorted(tag, expiry);
            push_result(ST_DONE, '0, 1'b1);
          end
        end
        MODE_ADJUST: begin
          if (pos < 0) begin
            push_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            close_gap(pos);
            place_sorted(tag, expiry);
            push_result(ST_DONE, '0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (pos < 0) begin
            push_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            close_gap(pos);
            push_result(ST_DONE, '0, 1'b1);
          end
        end
        default: begin
          n = 0;
          while (n < MAX_RESULTS && row_count > 0 && row_expiry[0] <= now) begin
            push_result(ST_EXPIRED, row_tag[0], 1'b0);
            close_gap(0);
            n++;
          end
          if (n == 0) push_result(ST_NONE_DUE, '0, 1'b1);
          else due_results[due_results.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Compare one result from the block with the oldest expectation.
    task check_result(logic [STATUS_W-1:0] status, logic [TAG_W-1:0] tag, logic last);
      timer_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d tag=%h last=%0d",
                                  status, tag, last));
      end else begin
        want = due_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("out_status got %0d want %0d", status, want.status));
        if (tag !== want.tag)
          report_mismatch($sformatf("out_expired_tag got %h want %h", tag, want.tag));
        if (last !== want.last)
          report_mismatch($sformatf("out_last got %0d want %0d", last, want.last));
      end
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [TAG_W-1:0]    in_conn_tag;
  logic [EXP_W-1:0]    in_expire_time;
  logic [EXP_W-1:0]    in_now_time;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_expired_tag;
  logic                out_last;

  timer_scoreboard sb;
  bit              idle_enable;
  logic [EXP_W-1:0] cur_time;

  sorted_timer_queue #(.CAPACITY(ROW_CAP)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_conn_tag(in_conn_tag),
    .in_expire_time(in_expire_time),
    .in_now_time(in_now_time),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_expired_tag(out_expired_tag),
    .out_last(out_last)
  );

  // 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one item, idling at random first, and note it once it is accepted.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                           input logic [EXP_W-1:0] expiry, input logic [EXP_W-1:0] now);
    while (idle_enable && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_conn_tag <= tag;
    in_expire_time <= expiry;
    in_now_time <= now;
    do @(posedge clk); while (busy);
    sb.note_item(mode, tag, expiry, now);
  endtask

  // Mostly a small pool of tags so that hits and duplicates are common.
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(99) < 80) return TAG_W'($urandom_range(19));
    return TAG_W'($urandom);
  endfunction

  function automatic logic [EXP_W-1:0] pick_expiry();
    if ($urandom_range(99) < 10) return $urandom;
    return cur_time + $urandom_range(40);
  endfunction

  // Every result is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_status, out_expired_tag, out_last);
  end

  // Stimulus and end of run.
  initial begin
    int sel;
    logic [EXP_W-1:0] now;
    sb = new();
    idle_enable = 1'b1;
    cur_time = $urandom;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_ADD;
    in_conn_tag <= '0;
    in_expire_time <= '0;
    in_now_time <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty row, absent tags, extremes, equal expiries, both adjust directions.
    send_item(MODE_TICK, '0, '0, '0);
    send_item(MODE_DELETE, 16'h0005, '0, '1);
    send_item(MODE_ADJUST, 16'h0005, 32'h0000_0010, '0);
    send_item(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, '0);
    send_item(MODE_ADD, 16'h0000, 32'h0000_0000, '1);
    send_item(MODE_ADD, 16'h0000, 32'h0000_0040, '0);
    send_item(MODE_ADD, 16'h0001, 32'd100, '0);
    send_item(MODE_ADD, 16'h0002, 32'd100, '0);
    send_item(MODE_ADJUST, 16'h0001, 32'd100, '0);
    send_item(MODE_ADJUST, 16'hFFFF, 32'd50, '0);
    send_item(MODE_ADJUST, 16'h0000, 32'd200, '0);
    send_item(MODE_TICK, '0, '1, 32'd99);
    send_item(MODE_DELETE, 16'h0002, '0, '0);

    // Fill the row, then a full add and a duplicate on a full row.
    for (int i = 0; i < ROW_CAP - 2; i++)
      send_item(MODE_ADD, 16'h0100 + TAG_W'(i), $urandom_range(300), '0);
    send_item(MODE_ADD, 16'h0200, 32'd5, '0);
    send_item(MODE_ADD, 16'h0001, 32'd5, '0);

    // A tick that flushes the whole row, then one on the empty row.
    send_item(MODE_TICK, '0, '0, 32'hFFFF_FFFF);
    send_item(MODE_TICK, '0, '0, 32'hFFFF_FFFF);

    // Random part, with a stretch in the middle that never idles.
    for (int i = 0; i < 170; i++) begin
      idle_enable = !(i >= 60 && i < 120);
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_item(MODE_ADD, pick_tag(), pick_expiry(), $urandom);
      end else if (sel < 55) begin
        send_item(MODE_ADJUST, pick_tag(), pick_expiry(), $urandom);
      end else if (sel < 70) begin
        send_item(MODE_DELETE, pick_tag(), $urandom, $urandom);
      end else begin
        cur_time = cur_time + $urandom_range(15);
        now = ($urandom_range(99) < 10) ? $urandom : cur_time;
        send_item(MODE_TICK, TAG_W'($urandom), $urandom, now);
      end
    end
    start <= 1'b0;

    // Drain the outstanding results, then watch for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule
